### src/fvps_pkg.sv
// shared types and constants for the flush valve and pump sequencer
`timescale 1ns / 1ps

package fvps_pkg;

  // sequencer phase codes, codes above clear behave as a clear
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_SETTLE    = 4'd1,
    PH_CHOOSE    = 4'd2,
    PH_BIG_LEAD  = 4'd3,
    PH_BIG_PUMP  = 4'd4,
    PH_BIG_TAIL  = 4'd5,
    PH_BIG_RINSE = 4'd6,
    PH_SML_LEAD  = 4'd7,
    PH_SML_PUMP  = 4'd8,
    PH_SML_TAIL  = 4'd9,
    PH_END_WAIT  = 4'd10,
    PH_CLEAR     = 4'd11
  } phase_t;

  // configuration register word index (byte address / 4)
  typedef enum logic [2:0] {
    REG_DUAL_MODE   = 3'd0,
    REG_SETTLE      = 3'd1,
    REG_BIG_LEAD    = 3'd2,
    REG_BIG_PUMP    = 3'd3,
    REG_BIG_RINSE   = 3'd4,
    REG_SMALL_LEAD  = 3'd5,
    REG_SMALL_PUMP  = 3'd6
  } reg_idx_t;

  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TICK_W  = 16;

  // reset values of the timing registers
  localparam logic              DUAL_MODE_RST   = 1'b1;
  localparam logic [TICK_W-1:0] SETTLE_RST      = 16'd5;
  localparam logic [TICK_W-1:0] BIG_LEAD_RST    = 16'd10;
  localparam logic [TICK_W-1:0] BIG_PUMP_RST    = 16'd100;
  localparam logic [TICK_W-1:0] BIG_RINSE_RST   = 16'd200;
  localparam logic [TICK_W-1:0] SMALL_LEAD_RST  = 16'd5;
  localparam logic [TICK_W-1:0] SMALL_PUMP_RST  = 16'd100;

endpackage

### src/fvps_in_if.sv
// input channel carrying one tick of presence flags per beat
`timescale 1ns / 1ps

interface fvps_in_if;
  logic valid;
  logic ready;
  logic present_long;
  logic present_short;
  logic user_left;
  logic present_now;

  modport source (output valid, present_long, present_short, user_left, present_now,
                  input ready);
  modport sink   (input valid, present_long, present_short, user_left, present_now,
                  output ready);
endinterface

### src/fvps_out_if.sv
// result channel carrying actuator drives and phase per beat
`timescale 1ns / 1ps

interface fvps_out_if;
  logic       valid;
  logic       ready;
  logic       air_pump;
  logic       main_valve;
  logic       direct_valve;
  logic       busy_res;
  logic [3:0] phase;

  modport source (output valid, air_pump, main_valve, direct_valve, busy_res, phase,
                  input ready);
  modport sink   (input valid, air_pump, main_valve, direct_valve, busy_res, phase,
                  output ready);
endinterface

### src/flush_valve_pump_sequencer.sv
// flush valve and pump sequencer: request latch, timed phase sequencer, apb registers
// path: each accepted tick beat passes the input register, then the result register
// throughput: one tick beat per cycle while the result receiver keeps taking beats, set by the
//   combinational sequencer update between the input register and the result register
// reset: synchronous active-low rst_n returns the sequencer to idle, clears the
//   tick counter, grants and pending departure, and loads the register defaults
`timescale 1ns / 1ps

module flush_valve_pump_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  fvps_in_if.sink                        in_ch,
  fvps_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fvps_pkg::ADDR_W-1:0]    paddr,
  input  logic [fvps_pkg::DATA_W-1:0]    pwdata,
  output logic [fvps_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  // configuration registers
  logic                          dual_mode_r;
  logic [fvps_pkg::TICK_W-1:0]   settle_r;
  logic [fvps_pkg::TICK_W-1:0]   big_lead_r;
  logic [fvps_pkg::TICK_W-1:0]   big_pump_r;
  logic [fvps_pkg::TICK_W-1:0]   big_rinse_r;
  logic [fvps_pkg::TICK_W-1:0]   small_lead_r;
  logic [fvps_pkg::TICK_W-1:0]   small_pump_r;

  logic                          cfg_wr;
  fvps_pkg::reg_idx_t            cfg_idx;
  logic [fvps_pkg::TICK_W-1:0]   cfg_wdata;

  // input register
  logic in_vld_r;
  logic p_long_r;
  logic p_short_r;
  logic left_r;
  logic now_r;

  // sequencer state
  fvps_pkg::phase_t              phase_r, phase_nxt;
  logic [fvps_pkg::TICK_W-1:0]   tick_cnt_r, tick_cnt_nxt;
  logic                          leave_r, leave_nxt;
  logic                          grant_big_r, grant_big_nxt;
  logic                          grant_sml_r, grant_sml_nxt;
  logic                          busy_r, busy_nxt;

  // result register
  logic out_vld_r;
  logic pump_r, pump_nxt;
  logic mainv_r, mainv_nxt;
  logic direct_r, direct_nxt;

  // combinational helpers
  logic                          advance;
  logic                          req_big;
  logic                          req_sml;
  logic                          leave_seen;
  logic [fvps_pkg::TICK_W-1:0]   cnt_inc;
  logic [fvps_pkg::TICK_W-1:0]   limit;
  logic                          expired;

  // apb decode
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;
  assign cfg_idx   = fvps_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wdata = pwdata[fvps_pkg::TICK_W-1:0];

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dual_mode_r  <= fvps_pkg::DUAL_MODE_RST;
      settle_r     <= fvps_pkg::SETTLE_RST;
      big_lead_r   <= fvps_pkg::BIG_LEAD_RST;
      big_pump_r   <= fvps_pkg::BIG_PUMP_RST;
      big_rinse_r  <= fvps_pkg::BIG_RINSE_RST;
      small_lead_r <= fvps_pkg::SMALL_LEAD_RST;
      small_pump_r <= fvps_pkg::SMALL_PUMP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        fvps_pkg::REG_DUAL_MODE:  dual_mode_r  <= cfg_wdata[0];
        fvps_pkg::REG_SETTLE:     settle_r     <= cfg_wdata;
        fvps_pkg::REG_BIG_LEAD:   big_lead_r   <= cfg_wdata;
        fvps_pkg::REG_BIG_PUMP:   big_pump_r   <= cfg_wdata;
        fvps_pkg::REG_BIG_RINSE:  big_rinse_r  <= cfg_wdata;
        fvps_pkg::REG_SMALL_LEAD: small_lead_r <= cfg_wdata;
        fvps_pkg::REG_SMALL_PUMP: small_pump_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      fvps_pkg::REG_DUAL_MODE:  prdata = {{(fvps_pkg::DATA_W-1){1'b0}}, dual_mode_r};
      fvps_pkg::REG_SETTLE:     prdata = {16'd0, settle_r};
      fvps_pkg::REG_BIG_LEAD:   prdata = {16'd0, big_lead_r};
      fvps_pkg::REG_BIG_PUMP:   prdata = {16'd0, big_pump_r};
      fvps_pkg::REG_BIG_RINSE:  prdata = {16'd0, big_rinse_r};
      fvps_pkg::REG_SMALL_LEAD: prdata = {16'd0, small_lead_r};
      fvps_pkg::REG_SMALL_PUMP: prdata = {16'd0, small_pump_r};
      default:                  prdata = '0;
    endcase
  end

  // pipeline flow: the held beat moves on when the result slot is free or drained
  assign advance     = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !in_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      p_long_r  <= in_ch.present_long;
      p_short_r <= in_ch.present_short;
      left_r    <= in_ch.user_left;
      now_r     <= in_ch.present_now;
    end
  end

  // request stage: flush size from presence time, grant on departure when not busy
  always_comb begin
    req_big = dual_mode_r ? p_long_r : p_short_r;
    req_sml = dual_mode_r & ~p_long_r & p_short_r;
    leave_seen    = leave_r | left_r;
    leave_nxt     = leave_seen;
    grant_big_nxt = grant_big_r;
    grant_sml_nxt = grant_sml_r;
    if (leave_seen && !busy_r) begin
      leave_nxt = 1'b0;
      if (req_big) begin
        grant_big_nxt = 1'b1;
      end else if (req_sml) begin
        grant_sml_nxt = 1'b1;
      end
    end
  end

  // limit of the current timed phase
  always_comb begin
    case (phase_r)
      fvps_pkg::PH_SETTLE,
      fvps_pkg::PH_END_WAIT:   limit = settle_r;
      fvps_pkg::PH_BIG_LEAD,
      fvps_pkg::PH_BIG_TAIL:   limit = big_lead_r;
      fvps_pkg::PH_BIG_PUMP:   limit = big_pump_r;
      fvps_pkg::PH_BIG_RINSE:  limit = big_rinse_r;
      fvps_pkg::PH_SML_LEAD,
      fvps_pkg::PH_SML_TAIL:   limit = small_lead_r;
      fvps_pkg::PH_SML_PUMP:   limit = small_pump_r;
      default:                 limit = '0;
    endcase
  end

  assign cnt_inc = tick_cnt_r + 16'd1;
  assign expired = (cnt_inc >= limit);

  // sequencer next state and drives
  always_comb begin
    phase_nxt    = phase_r;
    tick_cnt_nxt = tick_cnt_r;
    busy_nxt     = 1'b1;
    pump_nxt     = 1'b0;
    mainv_nxt    = 1'b0;
    direct_nxt   = 1'b0;
    unique case (phase_r)
      fvps_pkg::PH_IDLE: begin
        busy_nxt = 1'b0;
        if (grant_big_nxt || grant_sml_nxt) begin
          phase_nxt    = fvps_pkg::PH_SETTLE;
          tick_cnt_nxt = '0;
        end
      end
      fvps_pkg::PH_SETTLE: begin
        if (now_r) begin
          phase_nxt    = fvps_pkg::PH_END_WAIT;
          tick_cnt_nxt = '0;
        end else begin
          tick_cnt_nxt = expired ? '0 : cnt_inc;
          if (expired) phase_nxt = fvps_pkg::PH_CHOOSE;
        end
      end
      fvps_pkg::PH_CHOOSE: begin
        if (now_r) begin
          phase_nxt    = fvps_pkg::PH_END_WAIT;
          tick_cnt_nxt = '0;
        end else if (grant_big_nxt) begin
          phase_nxt = fvps_pkg::PH_BIG_LEAD;
        end else if (grant_sml_nxt) begin
          phase_nxt = fvps_pkg::PH_SML_LEAD;
        end
      end
      fvps_pkg::PH_BIG_LEAD: begin
        mainv_nxt    = 1'b1;
        direct_nxt   = 1'b1;
        tick_cnt_nxt = expired ? '0 : cnt_inc;
        if (expired) phase_nxt = fvps_pkg::PH_BIG_PUMP;
      end
      fvps_pkg::PH_BIG_PUMP: begin
        pump_nxt     = 1'b1;
        mainv_nxt    = 1'b1;
        direct_nxt   = 1'b1;
        tick_cnt_nxt = expired ? '0 : cnt_inc;
        if (expired) phase_nxt = fvps_pkg::PH_BIG_TAIL;
      end
      fvps_pkg::PH_BIG_TAIL: begin
        mainv_nxt    = 1'b1;
        direct_nxt   = 1'b1;
        tick_cnt_nxt = expired ? '0 : cnt_inc;
        if (expired) phase_nxt = fvps_pkg::PH_BIG_RINSE;
      end
      fvps_pkg::PH_BIG_RINSE: begin
        direct_nxt   = 1'b1;
        tick_cnt_nxt = expired ? '0 : cnt_inc;
        if (expired) phase_nxt = fvps_pkg::PH_END_WAIT;
      end
      fvps_pkg::PH_SML_LEAD: begin
        mainv_nxt    = 1'b1;
        tick_cnt_nxt = expired ? '0 : cnt_inc;
        if (expired) phase_nxt = fvps_pkg::PH_SML_PUMP;
      end
      fvps_pkg::PH_SML_PUMP: begin
        pump_nxt     = 1'b1;
        mainv_nxt    = 1'b1;
        tick_cnt_nxt = expired ? '0 : cnt_inc;
        if (expired) phase_nxt = fvps_pkg::PH_SML_TAIL;
      end
      fvps_pkg::PH_SML_TAIL: begin
        mainv_nxt    = 1'b1;
        tick_cnt_nxt = expired ? '0 : cnt_inc;
        if (expired) phase_nxt = fvps_pkg::PH_END_WAIT;
      end
      fvps_pkg::PH_END_WAIT: begin
        tick_cnt_nxt = expired ? '0 : cnt_inc;
        if (expired) phase_nxt = fvps_pkg::PH_CLEAR;
      end
      // clear, and any unused code: back to idle with grants dropped
      default: begin
        busy_nxt     = 1'b0;
        phase_nxt    = fvps_pkg::PH_IDLE;
        tick_cnt_nxt = '0;
      end
    endcase
  end

  // state update, one step per beat leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fvps_pkg::PH_IDLE;
      tick_cnt_r  <= '0;
      leave_r     <= 1'b0;
      grant_big_r <= 1'b0;
      grant_sml_r <= 1'b0;
      busy_r      <= 1'b0;
    end else if (in_vld_r && advance) begin
      phase_r    <= phase_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      leave_r    <= leave_nxt;
      busy_r     <= busy_nxt;
      if (phase_nxt == fvps_pkg::PH_IDLE && phase_r != fvps_pkg::PH_IDLE) begin
        grant_big_r <= 1'b0;
        grant_sml_r <= 1'b0;
      end else begin
        grant_big_r <= grant_big_nxt;
        grant_sml_r <= grant_sml_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r && advance) begin
      pump_r   <= pump_nxt;
      mainv_r  <= mainv_nxt;
      direct_r <= direct_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.air_pump     = pump_r;
  assign out_ch.main_valve   = mainv_r;
  assign out_ch.direct_valve = direct_r;
  assign out_ch.busy_res     = busy_r;
  assign out_ch.phase        = phase_r;

endmodule

### bench/flush_valve_pump_sequencer_test.sv
// self-checking testbench for the flush valve and pump sequencer: directed, extreme and random ticks
`timescale 1ns / 1ps

module flush_valve_pump_sequencer_test;

  localparam int CLK_HALF        = 6;
  localparam int CYCLE_LIMIT     = 250000;
  localparam int DRAIN_PAD       = 6;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int PRESSURE_TICKS  = 40;
  localparam int RANDOM_ROUNDS   = 6;
  localparam int RANDOM_ITEMS    = 510;
  localparam int UNMAPPED_REG    = 7;
  localparam int REPORT_CAP      = 60;

  // one tick of presence flags, msb first: long, short, left, now
  typedef struct packed {
    logic present_long;
    logic present_short;
    logic user_left;
    logic present_now;
  } tick_t;

  typedef struct packed {
    logic       air_pump;
    logic       main_valve;
    logic       direct_valve;
    logic       busy_res;
    logic [3:0] phase;
  } drive_t;

  // departure with a grant while idle, abort, busy departure, small then big flush
  localparam logic [3:0] DIRECTED_TICKS [22] = '{
    4'b0000, 4'b1111, 4'b0001, 4'b0010, 4'b0000, 4'b0100,
    4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000,
    4'b1010,
    4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000
  };

  logic                        clk     = 1'b0;
  logic                        rst_n   = 1'b0;
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [fvps_pkg::ADDR_W-1:0] paddr   = '0;
  logic [fvps_pkg::DATA_W-1:0] pwdata  = '0;
  logic [fvps_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  fvps_in_if  in_ch ();
  fvps_out_if out_ch ();

  flush_valve_pump_sequencer u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // sequencer shadow: configuration
  logic                        dual_q       = fvps_pkg::DUAL_MODE_RST;
  logic [fvps_pkg::TICK_W-1:0] settle_q     = fvps_pkg::SETTLE_RST;
  logic [fvps_pkg::TICK_W-1:0] big_lead_q   = fvps_pkg::BIG_LEAD_RST;
  logic [fvps_pkg::TICK_W-1:0] big_pump_q   = fvps_pkg::BIG_PUMP_RST;
  logic [fvps_pkg::TICK_W-1:0] big_rinse_q  = fvps_pkg::BIG_RINSE_RST;
  logic [fvps_pkg::TICK_W-1:0] small_lead_q = fvps_pkg::SMALL_LEAD_RST;
  logic [fvps_pkg::TICK_W-1:0] small_pump_q = fvps_pkg::SMALL_PUMP_RST;

  // sequencer shadow: state
  fvps_pkg::phase_t            seq_phase     = fvps_pkg::PH_IDLE;
  logic [fvps_pkg::TICK_W-1:0] tick_cnt      = '0;
  logic                        leave_pend    = 1'b0;
  logic                        grant_big_q   = 1'b0;
  logic                        grant_small_q = 1'b0;
  logic                        busy_q        = 1'b0;

  drive_t expected_drives [$];
  int     mismatch_count = 0;
  int     ticks_sent     = 0;
  int     cycle_count    = 0;
  logic   brisk          = 1'b0;
  logic   hold_off_req   = 1'b0;

  always #(CLK_HALF) clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int expv, input int gotv);
    if (mismatch_count < REPORT_CAP)
      $display("mismatch %s: expected %0d got %0d, cycle %0d", what, expv, gotv, cycle_count);
    mismatch_count++;
  endtask

  // one tick of a timed phase
  function automatic void count_tick(input logic [fvps_pkg::TICK_W-1:0] limit,
                                     input fvps_pkg::phase_t nxt);
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= limit) begin
      tick_cnt  = '0;
      seq_phase = nxt;
    end
  endfunction

  // request stage then sequencer step; returns the drives after the tick
  function automatic drive_t advance_sequencer(input tick_t t);
    drive_t d;
    logic   want_big;
    logic   want_small;
    d          = '0;
    want_big   = 1'b0;
    want_small = 1'b0;
    if (dual_q) begin
      if (t.present_long) want_big = 1'b1;
      else if (t.present_short) want_small = 1'b1;
    end else if (t.present_short) begin
      want_big = 1'b1;
    end
    if (t.user_left) leave_pend = 1'b1;
    if (leave_pend && !busy_q) begin
      leave_pend = 1'b0;
      if (want_big) grant_big_q = 1'b1;
      else if (want_small) grant_small_q = 1'b1;
    end

    case (seq_phase)
      fvps_pkg::PH_IDLE: begin
        busy_q = 1'b0;
        if (grant_big_q || grant_small_q) begin
          seq_phase = fvps_pkg::PH_SETTLE;
          tick_cnt  = '0;
        end
      end
      fvps_pkg::PH_SETTLE: begin
        busy_q = 1'b1;
        if (t.present_now) begin
          seq_phase = fvps_pkg::PH_END_WAIT;
          tick_cnt  = '0;
        end else begin
          count_tick(settle_q, fvps_pkg::PH_CHOOSE);
        end
      end
      fvps_pkg::PH_CHOOSE: begin
        busy_q = 1'b1;
        if (t.present_now) begin
          seq_phase = fvps_pkg::PH_END_WAIT;
          tick_cnt  = '0;
        end else if (grant_big_q) begin
          seq_phase = fvps_pkg::PH_BIG_LEAD;
        end else if (grant_small_q) begin
          seq_phase = fvps_pkg::PH_SML_LEAD;
        end
      end
      fvps_pkg::PH_BIG_LEAD: begin
        busy_q = 1'b1; d.main_valve = 1'b1; d.direct_valve = 1'b1;
        count_tick(big_lead_q, fvps_pkg::PH_BIG_PUMP);
      end
      fvps_pkg::PH_BIG_PUMP: begin
        busy_q = 1'b1; d.air_pump = 1'b1; d.main_valve = 1'b1; d.direct_valve = 1'b1;
        count_tick(big_pump_q, fvps_pkg::PH_BIG_TAIL);
      end
      fvps_pkg::PH_BIG_TAIL: begin
        busy_q = 1'b1; d.main_valve = 1'b1; d.direct_valve = 1'b1;
        count_tick(big_lead_q, fvps_pkg::PH_BIG_RINSE);
      end
      fvps_pkg::PH_BIG_RINSE: begin
        busy_q = 1'b1; d.direct_valve = 1'b1;
        count_tick(big_rinse_q, fvps_pkg::PH_END_WAIT);
      end
      fvps_pkg::PH_SML_LEAD: begin
        busy_q = 1'b1; d.main_valve = 1'b1;
        count_tick(small_lead_q, fvps_pkg::PH_SML_PUMP);
      end
      fvps_pkg::PH_SML_PUMP: begin
        busy_q = 1'b1; d.air_pump = 1'b1; d.main_valve = 1'b1;
        count_tick(small_pump_q, fvps_pkg::PH_SML_TAIL);
      end
      fvps_pkg::PH_SML_TAIL: begin
        busy_q = 1'b1; d.main_valve = 1'b1;
        count_tick(small_lead_q, fvps_pkg::PH_END_WAIT);
      end
      fvps_pkg::PH_END_WAIT: begin
        busy_q = 1'b1;
        count_tick(settle_q, fvps_pkg::PH_CLEAR);
      end
      default: begin
        // clear and unused codes
        busy_q        = 1'b0;
        seq_phase     = fvps_pkg::PH_IDLE;
        tick_cnt      = '0;
        grant_big_q   = 1'b0;
        grant_small_q = 1'b0;
      end
    endcase

    d.busy_res = busy_q;
    d.phase    = seq_phase;
    return d;
  endfunction

  // offer one tick beat after a random gap, predict once accepted
  task automatic send_tick(input tick_t t);
    int gap;
    gap = brisk ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.present_long  <= t.present_long;
    in_ch.present_short <= t.present_short;
    in_ch.user_left     <= t.user_left;
    in_ch.present_now   <= t.present_now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_drives.push_back(advance_sequencer(t));
    ticks_sent++;
  endtask

  // stop offering and wait for every result, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // apb setup then access phase
  task automatic apb_access(input logic is_write, input int idx, input logic [15:0] value,
                            output logic [fvps_pkg::DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= fvps_pkg::ADDR_W'(idx * 4);
    pwdata  <= fvps_pkg::DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input int idx, input logic [15:0] value);
    logic [fvps_pkg::DATA_W-1:0] unused;
    apb_access(1'b1, idx, value, unused);
    case (idx)
      fvps_pkg::REG_DUAL_MODE:  dual_q       = value[0];
      fvps_pkg::REG_SETTLE:     settle_q     = value;
      fvps_pkg::REG_BIG_LEAD:   big_lead_q   = value;
      fvps_pkg::REG_BIG_PUMP:   big_pump_q   = value;
      fvps_pkg::REG_BIG_RINSE:  big_rinse_q  = value;
      fvps_pkg::REG_SMALL_LEAD: small_lead_q = value;
      fvps_pkg::REG_SMALL_PUMP: small_pump_q = value;
      default: ;
    endcase
  endtask

  task automatic check_readback(input int idx);
    logic [fvps_pkg::DATA_W-1:0] got;
    logic [fvps_pkg::DATA_W-1:0] want;
    apb_access(1'b0, idx, 16'd0, got);
    case (idx)
      fvps_pkg::REG_DUAL_MODE:  want = fvps_pkg::DATA_W'(dual_q);
      fvps_pkg::REG_SETTLE:     want = fvps_pkg::DATA_W'(settle_q);
      fvps_pkg::REG_BIG_LEAD:   want = fvps_pkg::DATA_W'(big_lead_q);
      fvps_pkg::REG_BIG_PUMP:   want = fvps_pkg::DATA_W'(big_pump_q);
      fvps_pkg::REG_BIG_RINSE:  want = fvps_pkg::DATA_W'(big_rinse_q);
      fvps_pkg::REG_SMALL_LEAD: want = fvps_pkg::DATA_W'(small_lead_q);
      default:                  want = fvps_pkg::DATA_W'(small_pump_q);
    endcase
    if (got !== want)
      report_mismatch($sformatf("register %0d readback", idx), int'(want), int'(got));
  endtask

  // result beat checker
  task automatic check_drive();
    drive_t want;
    if (expected_drives.size() == 0) begin
      report_mismatch("result beat with none pending", 0, 1);
      return;
    end
    want = expected_drives.pop_front();
    if (out_ch.air_pump !== want.air_pump)
      report_mismatch("air_pump", int'(want.air_pump), int'(out_ch.air_pump));
    if (out_ch.main_valve !== want.main_valve)
      report_mismatch("main_valve", int'(want.main_valve), int'(out_ch.main_valve));
    if (out_ch.direct_valve !== want.direct_valve)
      report_mismatch("direct_valve", int'(want.direct_valve), int'(out_ch.direct_valve));
    if (out_ch.busy_res !== want.busy_res)
      report_mismatch("busy_res", int'(want.busy_res), int'(out_ch.busy_res));
    if (out_ch.phase !== want.phase)
      report_mismatch("phase", int'(want.phase), int'(out_ch.phase));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_drive();
  end

  // result receiver: random stall per beat, one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        stall        = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        stall = brisk ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // every register bit both ways, readback, unmapped index ignored
  task automatic test_register_access();
    logic [15:0] patterns [4];
    patterns = '{16'hFFFF, 16'h0000, 16'hA5A5, 16'h5A5A};
    drain_results();
    for (int b = 0; b < 2; b++) begin
      write_reg(fvps_pkg::REG_DUAL_MODE, 16'(b));
      check_readback(fvps_pkg::REG_DUAL_MODE);
    end
    for (int idx = fvps_pkg::REG_SETTLE; idx <= fvps_pkg::REG_SMALL_PUMP; idx++) begin
      foreach (patterns[p]) begin
        write_reg(idx, patterns[p]);
        check_readback(idx);
      end
    end
    write_reg(UNMAPPED_REG, 16'h1234);
    for (int idx = fvps_pkg::REG_DUAL_MODE; idx <= fvps_pkg::REG_SMALL_PUMP; idx++)
      check_readback(idx);
    // short timings for the directed ticks
    write_reg(fvps_pkg::REG_DUAL_MODE, 16'd1);
    for (int idx = fvps_pkg::REG_SETTLE; idx <= fvps_pkg::REG_SMALL_PUMP; idx++)
      write_reg(idx, 16'd1);
  endtask

  task automatic test_directed_ticks();
    foreach (DIRECTED_TICKS[i]) send_tick(tick_t'(DIRECTED_TICKS[i]));
  endtask

  // zero limits, largest limits, single mode requests
  task automatic test_limit_extremes();
    tick_t t;
    drain_results();
    write_reg(fvps_pkg::REG_DUAL_MODE, 16'd0);
    write_reg(fvps_pkg::REG_SETTLE, 16'd0);
    write_reg(fvps_pkg::REG_BIG_LEAD, 16'd0);
    write_reg(fvps_pkg::REG_BIG_PUMP, 16'hFFFF);
    write_reg(fvps_pkg::REG_BIG_RINSE, 16'd0);
    // single mode: short presence at departure asks for a big flush
    t = '0;
    t.present_short = 1'b1;
    t.user_left     = 1'b1;
    send_tick(t);
    t = '0;
    repeat (30) send_tick(t);
    // pump limit below the running count expires on the next tick
    drain_results();
    write_reg(fvps_pkg::REG_BIG_PUMP, 16'd3);
    repeat (8) send_tick(t);
    // long presence alone asks for nothing in single mode
    t.present_long = 1'b1;
    t.user_left    = 1'b1;
    send_tick(t);
    t = '0;
    repeat (3) send_tick(t);
    // longest settle wait, aborted by returning presence
    drain_results();
    write_reg(fvps_pkg::REG_DUAL_MODE, 16'd1);
    write_reg(fvps_pkg::REG_SETTLE, 16'hFFFF);
    write_reg(fvps_pkg::REG_SMALL_LEAD, 16'd0);
    write_reg(fvps_pkg::REG_SMALL_PUMP, 16'd0);
    t.present_short = 1'b1;
    t.user_left     = 1'b1;
    send_tick(t);
    t = '0;
    repeat (10) send_tick(t);
    t.present_now = 1'b1;
    send_tick(t);
    t = '0;
    repeat (5) send_tick(t);
    drain_results();
    write_reg(fvps_pkg::REG_SETTLE, 16'd1);
    repeat (6) send_tick(t);
    // small flush with zero lead and pump limits
    t.present_short = 1'b1;
    t.user_left     = 1'b1;
    send_tick(t);
    t = '0;
    repeat (10) send_tick(t);
  endtask

  // receiver holds off while ticks keep coming, so the block backs up
  task automatic test_backpressure();
    tick_t t;
    brisk        = 1'b1;
    hold_off_req = 1'b1;
    t = '0;
    t.present_long = 1'b1;
    t.user_left    = 1'b1;
    send_tick(t);
    t = '0;
    repeat (PRESSURE_TICKS - 1) send_tick(t);
    drain_results();
    brisk = 1'b0;
  endtask

  // visits with random content under several settings, some noise in between
  task automatic test_random_flushes();
    tick_t t;
    int    n;
    int    target;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      drain_results();
      write_reg(fvps_pkg::REG_DUAL_MODE, 16'(round % 2));
      for (int idx = fvps_pkg::REG_SETTLE; idx <= fvps_pkg::REG_SMALL_PUMP; idx++)
        write_reg(idx, ($urandom_range(0, 39) == 0) ? 16'($urandom_range(7, 400))
                                                     : 16'($urandom_range(0, 6)));
      brisk  = (round == 2);
      target = ticks_sent + RANDOM_ITEMS / RANDOM_ROUNDS;
      while (ticks_sent < target) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise burst
          n = $urandom_range(1, 5);
          repeat (n) send_tick(tick_t'(4'($urandom_range(0, 15))));
        end else begin
          // user present for a while
          n = $urandom_range(1, 4);
          repeat (n) begin
            t               = '0;
            t.present_now   = 1'b1;
            t.present_short = 1'($urandom_range(0, 1));
            t.present_long  = 1'($urandom_range(0, 1));
            send_tick(t);
          end
          // departure beat carries the request
          t.user_left     = 1'b1;
          t.present_now   = ($urandom_range(0, 4) == 0);
          t.present_short = 1'($urandom_range(0, 1));
          t.present_long  = 1'($urandom_range(0, 1));
          send_tick(t);
          // quiet ticks let the flush run, presence now and then aborts a wait
          n = $urandom_range(0, 40);
          repeat (n) begin
            t             = '0;
            t.present_now = ($urandom_range(0, 24) == 0);
            send_tick(t);
          end
        end
      end
    end
    brisk = 1'b0;
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.present_long  = 1'b0;
    in_ch.present_short = 1'b0;
    in_ch.user_left     = 1'b0;
    in_ch.present_now   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_access();
    test_directed_ticks();
    test_limit_extremes();
    test_backpressure();
    test_random_flushes();

    drain_results();
    if (expected_drives.size() != 0)
      report_mismatch("results left over", 0, expected_drives.size());
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
src/fvps_pkg.sv
src/fvps_in_if.sv
src/fvps_out_if.sv
src/flush_valve_pump_sequencer.sv
bench/flush_valve_pump_sequencer_test.sv
